>>> hw/rtl/srm_pkg.sv
package srm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 4096;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CX_W       = 10;
  localparam int CY_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic            remove_bit;
    logic [CX_W-1:0] centre_x;
    logic [CY_W-1:0] centre_y;
    logic            last_of_frame;
  } result_t;

  // window: bits 0..2 top row, 3..5 middle, 6..8 bottom; bit 0 of a row is left
  function automatic logic staircase(input logic [8:0] win);
    logic c, n0, n1, n2, n3, n4, n5, n6, n7, a, b;
    c  = win[4];
    n0 = win[1];
    n1 = win[2];
    n2 = win[5];
    n3 = win[8];
    n4 = win[7];
    n5 = win[6];
    n6 = win[3];
    n7 = win[0];
    a = n0 & ((n6 & ~n3 & ~n7 & ~(n1 & n2 & n4 & n5)) |
              (n2 & ~n1 & ~n5 & ~(n3 & n4 & n6 & n7)));
    b = n4 & ((n2 & ~n3 & ~n7 & ~(n0 & n1 & n5 & n6)) |
              (n6 & ~n1 & ~n5 & ~(n0 & n2 & n3 & n7)));
    return c & (a | b);
  endfunction

endpackage

>>> hw/rtl/srm_pixel_if.sv
interface srm_pixel_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

>>> hw/rtl/srm_result_if.sv
interface srm_result_if;
  logic                      valid;
  logic                      ready;
  logic                      remove_bit;
  logic [srm_pkg::CX_W-1:0]  centre_x;
  logic [srm_pkg::CY_W-1:0]  centre_y;
  logic                      last_of_frame;

  modport source (output valid, output remove_bit, output centre_x, output centre_y,
                  output last_of_frame, input ready);
  modport sink (input valid, input remove_bit, input centre_x, input centre_y,
                input last_of_frame, output ready);
endinterface

>>> hw/rtl/srm_cfg_if.sv
interface srm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srm_pkg::CFG_IDX_W-1:0]   index;
  logic [srm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/srm_ram.sv
module srm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = srm_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/staircase_removal_mask.sv
// Channel   Dir  Transaction payload
// in_chan   in   pixel
// out_chan  out  remove_bit, centre_x, centre_y, last_of_frame
// cfg_chan  in   index, data (0 = image_width, 1 = image_height)
//
// One pixel per clock while the queue has room; a result goes via the s1 register and the queue.
// The rate is set by the line store RAM: one read and one write port per cycle.
// Line stores need no clearing; stale entries feed only rows 0 and 1, which yield no result.
// Reset clears counters, window, result queue and registers to 1024 x 1024.
// A three-entry result queue absorbs output stalls; in_chan.ready drops when queue count plus s1 reach three.
module staircase_removal_mask #(
  parameter int MAX_WIDTH = srm_pkg::MAX_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  srm_pixel_if.sink    in_chan,
  srm_result_if.source out_chan,
  srm_cfg_if.sink      cfg_chan
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WCW = (XW + 1 > srm_pkg::IMG_W_W) ? XW + 1 : srm_pkg::IMG_W_W;
  localparam int YW  = srm_pkg::CY_W;
  localparam int HW  = srm_pkg::IMG_H_W;

  logic [srm_pkg::IMG_W_W-1:0] img_w_r, img_w_nxt;
  logic [HW-1:0]               img_h_r, img_h_nxt;
  logic [XW-1:0]               x_r, x_nxt;
  logic [YW-1:0]               y_r, y_nxt;
  logic [8:0]                  win_r, win_nxt;
  logic                        s1_valid_r;
  logic                        s1_pix_r;
  logic [XW-1:0]               s1_x_r;
  logic [YW-1:0]               s1_y_r;

  srm_pkg::result_t            fifo_r [3];
  logic [1:0]                  wr_ptr_r, rd_ptr_r;
  logic [1:0]                  cnt_r, cnt_nxt;

  logic [WCW-1:0]              w_cmp, w_eff;
  logic [XW-1:0]               w_last;
  logic [HW-1:0]               h_eff;
  logic [YW-1:0]               h_last;
  logic                        in_acc, cfg_acc, cfg_hit, push, pop;
  logic [1:0]                  rd_data;
  logic [2:0]                  occ;
  srm_pkg::result_t            res;

  // effective frame size
  always_comb begin
    w_cmp = WCW'(img_w_r);
    if (w_cmp < WCW'(3)) begin
      w_eff = WCW'(3);
    end else if (w_cmp > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = w_cmp;
    end
    if (img_h_r < HW'(3)) begin
      h_eff = HW'(3);
    end else if (img_h_r > HW'(srm_pkg::HEIGHT_LIMIT)) begin
      h_eff = HW'(srm_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = img_h_r;
    end
  end

  assign w_last = XW'(w_eff - WCW'(1));
  assign h_last = YW'(h_eff - HW'(1));

  assign occ            = {1'b0, cnt_r} + {2'b00, s1_valid_r};
  assign in_chan.ready  = (occ <= 3'd2);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid && cfg_chan.ready;
  assign cfg_hit        = cfg_acc && (cfg_chan.index == srm_pkg::REG_IMAGE_WIDTH ||
                                      cfg_chan.index == srm_pkg::REG_IMAGE_HEIGHT);

  // line stores: bit 1 upper row, bit 0 middle row
  srm_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata ({rd_data[0], s1_pix_r}),
    .re    (in_acc),
    .raddr (x_r),
    .rdata (rd_data)
  );

  always_comb begin
    win_nxt = {s1_pix_r, win_r[8:7], rd_data[0], win_r[5:4], rd_data[1], win_r[2:1]};
    res.remove_bit    = srm_pkg::staircase(win_nxt);
    res.centre_x      = srm_pkg::CX_W'(s1_x_r - XW'(1));
    res.centre_y      = s1_y_r - YW'(1);
    res.last_of_frame = (s1_x_r == w_last) && (s1_y_r == h_last);
  end

  assign push = s1_valid_r && (s1_x_r >= XW'(2)) && (s1_y_r >= YW'(2));
  assign pop  = out_chan.valid && out_chan.ready;

  // column and row counters, configuration
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (in_acc) begin
      if (x_r == w_last) begin
        x_nxt = '0;
        y_nxt = (y_r == h_last) ? '0 : y_r + YW'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
    if (cfg_hit) begin
      x_nxt = '0;
      y_nxt = '0;
      if (cfg_chan.index == srm_pkg::REG_IMAGE_WIDTH) begin
        img_w_nxt = cfg_chan.data[srm_pkg::IMG_W_W-1:0];
      end else begin
        img_h_nxt = cfg_chan.data[HW-1:0];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= srm_pkg::IMG_W_W'(1024);
      img_h_r    <= HW'(1024);
      x_r        <= '0;
      y_r        <= '0;
      win_r      <= '0;
      s1_valid_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      img_w_r    <= img_w_nxt;
      img_h_r    <= img_h_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      s1_valid_r <= in_acc;
      cnt_r      <= cnt_nxt;
      if (cfg_hit) begin
        win_r <= '0;
      end else if (s1_valid_r) begin
        win_r <= win_nxt;
      end
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == 2'd2) ? 2'd0 : wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == 2'd2) ? 2'd0 : rd_ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_chan.pixel;
      s1_x_r   <= x_r;
      s1_y_r   <= y_r;
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.remove_bit    = fifo_r[rd_ptr_r].remove_bit;
  assign out_chan.centre_x      = fifo_r[rd_ptr_r].centre_x;
  assign out_chan.centre_y      = fifo_r[rd_ptr_r].centre_y;
  assign out_chan.last_of_frame = fifo_r[rd_ptr_r].last_of_frame;

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_valid_r) |-> (x_r != s1_x_r))
    else $error("line store read and write hit the same entry");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r != 2'd3))
    else $error("result queue overflow");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (s1_valid_r && $past(x_r) == s1_x_r))
    else $error("accepted pixel lost before line store update");

endmodule

>>> tb/srm_decision_checker.sv
`timescale 1ns / 100ps
module srm_decision_checker #(
  parameter int MAX_WIDTH = srm_pkg::MAX_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  srm_pixel_if  in_chan,
  srm_result_if out_chan,
  srm_cfg_if    cfg_chan,
  output int    mismatch_count,
  output int    decisions_pending
);

  logic                        upper_row [MAX_WIDTH];
  logic                        middle_row [MAX_WIDTH];
  logic [8:0]                  win;
  int unsigned                 col;
  int unsigned                 row;
  logic [srm_pkg::IMG_W_W-1:0] width_reg;
  logic [srm_pkg::IMG_H_W-1:0] height_reg;
  srm_pkg::result_t            pending_decisions [$];

  function automatic logic holt_remove(input logic [8:0] w);
    logic [7:0] ring;
    logic       north_step;
    logic       south_step;
    ring = {w[0], w[3], w[6], w[7], w[8], w[5], w[2], w[1]};
    north_step = ring[0] &
      ((ring[6] & !ring[3] & !ring[7] & !(&{ring[1], ring[2], ring[4], ring[5]})) |
       (ring[2] & !ring[1] & !ring[5] & !(&{ring[3], ring[4], ring[6], ring[7]})));
    south_step = ring[4] &
      ((ring[2] & !ring[3] & !ring[7] & !(&{ring[0], ring[1], ring[5], ring[6]})) |
       (ring[6] & !ring[1] & !ring[5] & !(&{ring[0], ring[2], ring[3], ring[7]})));
    return w[4] & (north_step | south_step);
  endfunction

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 3) return 3;
    if (height_reg > srm_pkg::HEIGHT_LIMIT) return srm_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  task automatic take_pixel(input logic p);
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      x;
    int unsigned      y;
    logic             up;
    logic             mid;
    srm_pkg::result_t d;
    wd = active_width();
    ht = active_height();
    x = col;
    y = row;
    if (x >= wd) x = 0;
    up = upper_row[x];
    mid = middle_row[x];
    win = {p, win[8:7], mid, win[5:4], up, win[2:1]};
    upper_row[x] = mid;
    middle_row[x] = p;
    if (x >= 2 && y >= 2) begin
      d.remove_bit = holt_remove(win);
      d.centre_x = srm_pkg::CX_W'(x - 1);
      d.centre_y = srm_pkg::CY_W'(y - 1);
      d.last_of_frame = (x == wd - 1) && (y == ht - 1);
      pending_decisions.push_back(d);
    end
    x++;
    if (x >= wd) begin
      x = 0;
      y++;
      if (y >= ht) y = 0;
    end
    col = x;
    row = y;
  endtask

  task automatic check_result();
    srm_pkg::result_t want;
    if (pending_decisions.size() == 0) begin
      $error("unexpected transaction: remove_bit %0b centre_x %0d centre_y %0d last %0b",
             out_chan.remove_bit, out_chan.centre_x, out_chan.centre_y,
             out_chan.last_of_frame);
      mismatch_count++;
      return;
    end
    want = pending_decisions.pop_front();
    if (out_chan.remove_bit !== want.remove_bit) begin
      $error("remove_bit: expected %0b, got %0b", want.remove_bit, out_chan.remove_bit);
      mismatch_count++;
    end
    if (out_chan.centre_x !== want.centre_x) begin
      $error("centre_x: expected %0d, got %0d", want.centre_x, out_chan.centre_x);
      mismatch_count++;
    end
    if (out_chan.centre_y !== want.centre_y) begin
      $error("centre_y: expected %0d, got %0d", want.centre_y, out_chan.centre_y);
      mismatch_count++;
    end
    if (out_chan.last_of_frame !== want.last_of_frame) begin
      $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
             out_chan.last_of_frame);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (upper_row[i]) upper_row[i] = 1'b0;
      foreach (middle_row[i]) middle_row[i] = 1'b0;
      win = '0;
      col = 0;
      row = 0;
      width_reg = srm_pkg::IMG_W_W'(1024);
      height_reg = srm_pkg::IMG_H_W'(1024);
      pending_decisions.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == srm_pkg::REG_IMAGE_WIDTH) begin
          width_reg = cfg_chan.data[srm_pkg::IMG_W_W-1:0];
        end
        if (cfg_chan.index == srm_pkg::REG_IMAGE_HEIGHT) begin
          height_reg = cfg_chan.data[srm_pkg::IMG_H_W-1:0];
        end
        if (cfg_chan.index == srm_pkg::REG_IMAGE_WIDTH ||
            cfg_chan.index == srm_pkg::REG_IMAGE_HEIGHT) begin
          col = 0;
          row = 0;
          win = '0;
        end
      end
      if (in_chan.valid && in_chan.ready) take_pixel(in_chan.pixel);
      if (out_chan.valid && out_chan.ready) check_result();
    end
    decisions_pending = pending_decisions.size();
  end

endmodule

>>> tb/staircase_removal_mask_test.sv
`timescale 1ns / 100ps
module staircase_removal_mask_test;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  int   mismatch_count;
  int   decisions_pending;

  srm_pixel_if  in_chan();
  srm_result_if out_chan();
  srm_cfg_if    cfg_chan();

  staircase_removal_mask u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  srm_decision_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_chan           (in_chan),
    .out_chan          (out_chan),
    .cfg_chan          (cfg_chan),
    .mismatch_count    (mismatch_count),
    .decisions_pending (decisions_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("staircase_removal_mask regression: fail");
    $finish;
  end

  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(input logic p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.pixel <= p;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_row(input logic [2:0] bits);
    send_pixel(bits[2]);
    send_pixel(bits[1]);
    send_pixel(bits[0]);
  endtask

  task automatic write_reg(input logic [srm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srm_pkg::CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [srm_pkg::CFG_DATA_W-1:0] w_data,
                           input logic [srm_pkg::CFG_DATA_W-1:0] h_data);
    write_reg(srm_pkg::REG_IMAGE_WIDTH, w_data);
    write_reg(srm_pkg::REG_IMAGE_HEIGHT, h_data);
    cfg_chan.valid <= 1'b0;
  endtask

  // drop valid, wait for every decision, then let the pipeline drain
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (decisions_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [srm_pkg::CFG_DATA_W-1:0] w_data,
                           input logic [srm_pkg::CFG_DATA_W-1:0] h_data,
                           input int count, input int sp, input int rp,
                           input int density);
    configure(w_data, h_data);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    repeat (count) send_pixel($urandom_range(99) < density);
    settle();
  endtask

  initial begin
    int          send_pcts [4];
    int          recv_pcts [4];
    int unsigned w_pick;
    int unsigned h_pick;
    send_pcts = '{0, 74, 0, 21};
    recv_pcts = '{0, 0, 74, 21};
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.pixel = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // north-west step, blank centre, south-east step; last row ends the frame
    configure(16'd3, 16'd5);
    send_row(3'b010);
    send_row(3'b110);
    send_row(3'b000);
    send_row(3'b011);
    send_row(3'b010);
    settle();

    // undersized registers clamp to a 3x3 frame; north-east step
    configure(16'd0, 16'd2);
    send_row(3'b010);
    send_row(3'b011);
    send_row(3'b000);
    settle();

    // oversized height register; no frame end within the run
    run_phase(16'd3, 16'hFFFF, 300, 0, 0, 50);
    // oversized width register
    run_phase(16'hFFFF, 16'd3, 40, 21, 21, 50);
    run_phase(16'd1024, 16'd4096, 40, 21, 21, 50);

    for (int k = 0; k < 10; k++) begin
      w_pick = $urandom_range(10, 3);
      h_pick = $urandom_range(9, 3);
      if (k == 3) w_pick = $urandom_range(2, 0);
      if (k == 5) h_pick = $urandom_range(2, 0);
      if (k == 7) w_pick = $urandom_range(2047, 1025);
      run_phase(16'($urandom & 32'hF800) | 16'(w_pick),
                16'($urandom & 32'hE000) | 16'(h_pick),
                90, send_pcts[k % 4], recv_pcts[k % 4], $urandom_range(75, 25));

      // unknown register indexes must leave the frame running
      if (k == 4) begin
        write_reg(8'd2, 16'($urandom));
        write_reg(8'hFF, 16'hFFFF);
        cfg_chan.valid <= 1'b0;
        repeat (150) send_pixel($urandom_range(1, 0));
        settle();
      end
    end

    // hold the result side off so the input stalls
    hold_req = 1'b1;
    run_phase(16'd3, 16'd6, 400, 0, 0, 50);

    if (mismatch_count == 0 && decisions_pending == 0) begin
      $display("staircase_removal_mask regression: pass");
    end else begin
      $display("staircase_removal_mask regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/srm_pkg.sv
hw/rtl/srm_pixel_if.sv
hw/rtl/srm_result_if.sv
hw/rtl/srm_cfg_if.sv
hw/rtl/srm_ram.sv
hw/rtl/staircase_removal_mask.sv
tb/srm_decision_checker.sv
tb/staircase_removal_mask_test.sv
